// ===== hdl/pss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Parabolic step select package
// Shared types, widths and codes for the parabolic step select core.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int WIDE           = 104;
    localparam int QUOT_W         = 32;
    localparam int SHRINK_DIVISOR = 100;

    localparam logic [1:0] KIND_VERTEX  = 2'd0;
    localparam logic [1:0] KIND_CLAMP   = 2'd1;
    localparam logic [1:0] KIND_REDUCED = 2'd2;
    localparam logic [1:0] KIND_DEGEN   = 2'd3;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_SHRINK = 2'd2;

    typedef struct packed {
        logic signed [31:0] step_a;
        logic signed [31:0] misfit_a;
        logic signed [31:0] step_b;
        logic signed [31:0] misfit_b;
        logic signed [31:0] step_c;
        logic signed [31:0] misfit_c;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] chosen_step;
        logic [1:0]         choice_kind;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         kind;
        logic               neg;
        logic signed [31:0] value;
    } t_div_tag;

    typedef struct packed {
        logic               degen;
        logic               sd_neg;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
    } t_side;

endpackage
`default_nettype wire

// ===== hdl/parabolic_step_select_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Parabolic step select core
// Each accepted transaction passes the setup registers, the quotient pipeline
// and the output register. Throughput: one transaction per cycle, set by the
// 32-stage quotient pipeline. Busy stays low and the receiver cannot stall.
// Reset is synchronous and active low; it clears all valid bits.
// ----------------------------------------------------------------------------
module parabolic_step_select_core
    import pss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_strobe,
    output t_out_item      o_result
);

    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_in_item r_in;
    t_side r_sd1, r_sd2, r_sd3, r_sd4, r_sd5;

    logic signed [32:0] r_d01, r_d02, r_d12, r_e0, r_e2, r_s01, r_s02, r_s12;
    logic signed [31:0] r_y0, r_y1, r_y2;
    logic signed [65:0] r_p1, r_p2;
    logic signed [64:0] r_q0, r_q1, r_q2;
    logic signed [32:0] r_s01b, r_s02b, r_s12b, r_s02c;
    logic signed [66:0] r_na3, r_na4, r_na5;
    logic signed [65:0] r_qh0, r_qh1, r_qh2;
    logic signed [65:0] r_ql0, r_ql1, r_ql2;
    logic signed [WIDE-1:0] r_nb4, r_nb5, r_lim5, r_mid5;
    logic signed [65:0] r_lh, r_mh;
    logic signed [67:0] r_ll, r_ml;
    logic [WIDE-1:0] r_num6, r_den6;
    t_div_tag r_tag6;

    logic signed [32:0] n_x0, n_x1, n_x2;
    logic signed [WIDE-1:0] n_nb, n_lim, n_mid;
    logic signed [34:0] n_na_lo;
    logic signed [32:0] n_na_hi, n_t2;
    logic [WIDE-1:0] n_num, n_den;
    t_div_tag n_tag;

    logic            w_dv;
    logic [QUOT_W-1:0] w_quot;
    t_div_tag        w_dtag;
    logic signed [31:0] n_res;

    assign busy = 1'b0;

    assign n_x0 = 33'(r_in.step_a);
    assign n_x1 = 33'(r_in.step_b);
    assign n_x2 = 33'(r_in.step_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;

        r_d01 <= n_x0 - n_x1;
        r_d02 <= n_x0 - n_x2;
        r_d12 <= n_x1 - n_x2;
        r_e0  <= 33'(r_in.misfit_a) - 33'(r_in.misfit_b);
        r_e2  <= 33'(r_in.misfit_c) - 33'(r_in.misfit_b);
        r_s01 <= n_x0 + n_x1;
        r_s02 <= n_x0 + n_x2;
        r_s12 <= n_x1 + n_x2;
        r_y0  <= r_in.misfit_a;
        r_y1  <= r_in.misfit_b;
        r_y2  <= r_in.misfit_c;
        r_sd1.degen  <= (n_x0 == n_x1) || (n_x0 == n_x2) || (n_x1 == n_x2);
        r_sd1.sd_neg <= 1'b0;
        r_sd1.x0     <= r_in.step_a;
        r_sd1.x1     <= r_in.step_b;
        r_sd1.x2     <= r_in.step_c;

        r_p1 <= 66'(r_e0) * 66'(r_d12);
        r_p2 <= 66'(r_e2) * 66'(r_d01);
        r_q0 <= 65'(r_y0) * 65'(r_d12);
        r_q1 <= 65'(r_y1) * 65'(r_d02);
        r_q2 <= 65'(r_y2) * 65'(r_d01);
        r_s01b <= r_s01;
        r_s02b <= r_s02;
        r_s12b <= r_s12;
        r_sd2 <= '{degen:  r_sd1.degen,
                   sd_neg: r_d01[32] ^ r_d02[32] ^ r_d12[32],
                   x0:     r_sd1.x0,
                   x1:     r_sd1.x1,
                   x2:     r_sd1.x2};

        r_na3 <= 67'(r_p1) + 67'(r_p2);
        r_qh0 <= 66'($signed(r_q0[64:32])) * 66'(r_s12b);
        r_qh1 <= 66'($signed(r_q1[64:32])) * 66'(r_s02b);
        r_qh2 <= 66'($signed(r_q2[64:32])) * 66'(r_s01b);
        r_ql0 <= 66'($signed({1'b0, r_q0[31:0]})) * 66'(r_s12b);
        r_ql1 <= 66'($signed({1'b0, r_q1[31:0]})) * 66'(r_s02b);
        r_ql2 <= 66'($signed({1'b0, r_q2[31:0]})) * 66'(r_s01b);
        r_s02c <= r_s02b;
        r_sd3 <= r_sd2;

        r_nb4 <= n_nb;
        r_na4 <= r_na3;
        r_lh  <= 66'(n_na_hi) * 66'(n_t2);
        r_ll  <= 68'(n_na_lo) * 68'(n_t2);
        r_mh  <= 66'(n_na_hi) * 66'(r_s02c);
        r_ml  <= 68'(n_na_lo) * 68'(r_s02c);
        r_sd4 <= r_sd3;

        r_nb5  <= r_nb4;
        r_na5  <= r_na4;
        r_lim5 <= n_lim;
        r_mid5 <= n_mid;
        r_sd5  <= r_sd4;

        r_num6 <= n_num;
        r_den6 <= n_den;
        r_tag6 <= n_tag;
    end

    always_comb begin
        n_nb = ((WIDE'(r_qh0) <<< 32) + WIDE'(r_ql0))
             - ((WIDE'(r_qh1) <<< 32) + WIDE'(r_ql1))
             + ((WIDE'(r_qh2) <<< 32) + WIDE'(r_ql2));
        n_na_lo = $signed({1'b0, r_na3[33:0]});
        n_na_hi = $signed(r_na3[66:34]);
        n_t2    = $signed({r_sd3.x2, 1'b0});
        n_lim   = (WIDE'(r_lh) <<< 34) + WIDE'(r_ll);
        n_mid   = (WIDE'(r_mh) <<< 34) + WIDE'(r_ml);
    end

    always_comb begin
        logic na_zero, na_neg, nb_zero, nb_neg, sa_pos, beyond, below;
        logic signed [32:0] shrink_x;
        na_zero = (r_na5 == '0);
        na_neg  = r_na5[66];
        nb_zero = (r_nb5 == '0);
        nb_neg  = r_nb5[WIDE-1];
        sa_pos  = !na_zero && (na_neg == r_sd5.sd_neg);
        beyond  = na_neg ? (r_nb5 < r_lim5) : (r_nb5 > r_lim5);
        below   = na_neg ? (r_nb5 > r_mid5) : (r_nb5 < r_mid5);

        n_tag.mode  = MODE_DIRECT;
        n_tag.kind  = KIND_CLAMP;
        n_tag.value = r_sd5.x2;
        shrink_x    = 33'(r_sd5.x1);

        if (r_sd5.degen) begin
            n_tag.kind = KIND_DEGEN;
        end else if (na_zero) begin
            if (!(!nb_zero && (nb_neg != r_sd5.sd_neg))) begin
                n_tag.mode = MODE_SHRINK;
                n_tag.kind = KIND_REDUCED;
                shrink_x   = 33'(r_sd5.x0);
            end
        end else if (sa_pos) begin
            if (!nb_zero && (nb_neg != na_neg)) begin
                n_tag.mode = MODE_SHRINK;
                n_tag.kind = KIND_REDUCED;
            end else if (!beyond) begin
                n_tag.mode = MODE_VERTEX;
                n_tag.kind = KIND_VERTEX;
            end
        end else if (!below) begin
            n_tag.mode = MODE_SHRINK;
            n_tag.kind = KIND_REDUCED;
        end

        n_tag.neg = shrink_x[32];
        if (n_tag.mode == MODE_VERTEX) begin
            n_num = nb_neg ? WIDE'(-r_nb5) : WIDE'(r_nb5);
            n_den = na_neg ? (WIDE'(-r_na5) << 1) : (WIDE'(r_na5) << 1);
        end else begin
            n_num = shrink_x[32] ? WIDE'(-shrink_x) : WIDE'(shrink_x);
            n_den = WIDE'(SHRINK_DIVISOR);
        end
    end

    pss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_num   (r_num6),
        .i_den   (r_den6),
        .i_tag   (r_tag6),
        .o_valid (w_dv),
        .o_quot  (w_quot),
        .o_tag   (w_dtag)
    );

    always_comb begin
        unique case (w_dtag.mode)
            MODE_VERTEX: n_res = w_quot[QUOT_W-1] ? 32'sh7fffffff : $signed(w_quot);
            MODE_SHRINK: n_res = w_dtag.neg ? -$signed(w_quot) : $signed(w_quot);
            default:     n_res = w_dtag.value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= w_dv;
        end
        o_result.chosen_step <= n_res;
        o_result.choice_kind <= w_dtag.kind;
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv |=> o_strobe)
        else $error("quotient lost");
    a_vertex_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.choice_kind == KIND_VERTEX) |-> !o_result.chosen_step[31])
        else $error("negative vertex");
    a_degen_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 && (r_tag6.kind == KIND_DEGEN) |-> (r_tag6.mode == MODE_DIRECT))
        else $error("degenerate transaction routed to divider");

endmodule
`default_nettype wire

// ===== hdl/pss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage; a new division may enter every cycle.
// ----------------------------------------------------------------------------
module pss_div
    import pss_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [WIDE-1:0]   i_num,
    input  wire logic [WIDE-1:0]   i_den,
    input  wire t_div_tag          i_tag,
    output logic                   o_valid,
    output logic [QUOT_W-1:0]      o_quot,
    output t_div_tag               o_tag
);

    logic [WIDE-1:0]   r_num [QUOT_W];
    logic [WIDE-1:0]   r_den [QUOT_W];
    logic [QUOT_W-1:0] r_quot [QUOT_W];
    t_div_tag          r_tag [QUOT_W];
    logic [QUOT_W-1:0] r_vld;

    logic [WIDE-1:0]   n_num [QUOT_W];
    logic [QUOT_W-1:0] n_quot [QUOT_W];

    always_comb begin
        for (int k = 0; k < QUOT_W; k++) begin
            logic [WIDE-1:0]   num_in;
            logic [WIDE-1:0]   den_in;
            logic [QUOT_W-1:0] q_in;
            logic [WIDE-1:0]   trial;
            num_in = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k - 1];
            den_in = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            q_in   = (k == 0) ? '0 : r_quot[(k == 0) ? 0 : k - 1];
            trial  = den_in << (QUOT_W - 1 - k);
            if (trial <= num_in) begin
                n_num[k]  = num_in - trial;
                n_quot[k] = {q_in[QUOT_W-2:0], 1'b1};
            end else begin
                n_num[k]  = num_in;
                n_quot[k] = {q_in[QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QUOT_W-2:0], i_valid};
        end
        for (int k = 0; k < QUOT_W; k++) begin
            r_num[k]  <= n_num[k];
            r_quot[k] <= n_quot[k];
            r_den[k]  <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            r_tag[k]  <= (k == 0) ? i_tag : r_tag[(k == 0) ? 0 : k - 1];
        end
    end

    assign o_valid = r_vld[QUOT_W-1];
    assign o_quot  = r_quot[QUOT_W-1];
    assign o_tag   = r_tag[QUOT_W-1];

endmodule
`default_nettype wire

// ===== sim/tb_parabolic_step_select_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Parabolic step select core testbench
// Feeds directed and random sample triples through the core and checks every
// chosen step and choice kind against an exact wide-integer parabola fit.
// ----------------------------------------------------------------------------
module tb_parabolic_step_select_core;
    import pss_pkg::*;

    localparam int N_RANDOM   = 1080;
    localparam int WDOG_LIMIT = 3000;
    localparam int DRAIN_WAIT = 60;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_strobe;
    t_out_item o_result;

    t_in_item  pending_items[$];
    t_out_item expected_steps[$];
    int        n_accepted = 0;
    int        n_total = 0;
    int        wdog = 0;
    int        sender_idle_pct = 33;
    bit        pause_done = 1'b0;
    bit        failed = 1'b0;

    parabolic_step_select_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    function automatic int sign_of(logic signed [127:0] v);
        return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
    endfunction

    function automatic t_out_item fit_parabola_step(t_in_item it);
        logic signed [127:0] x0, x1, x2, y0, y1, y2, d01, d02, d12;
        logic signed [127:0] na, nb, lim, mid, un, ud, res;
        int sd, sna, snb, sa;
        t_out_item r;
        x0 = it.step_a;  y0 = it.misfit_a;
        x1 = it.step_b;  y1 = it.misfit_b;
        x2 = it.step_c;  y2 = it.misfit_c;
        d01 = x0 - x1;  d02 = x0 - x2;  d12 = x1 - x2;
        if (d01 == 0 || d02 == 0 || d12 == 0) begin
            res = x2;
            r.choice_kind = KIND_DEGEN;
        end else begin
            sd = sign_of(d01) * sign_of(d02) * sign_of(d12);
            na = (y0 - y1) * d12 + (y2 - y1) * d01;
            nb = y0 * d12 * (x1 + x2) - y1 * d02 * (x0 + x2) + y2 * d01 * (x0 + x1);
            sna = sign_of(na);
            snb = sign_of(nb);
            sa = sna * sd;
            if (sa == 0) begin
                if (-snb * sd > 0) begin
                    res = x2; r.choice_kind = KIND_CLAMP;
                end else begin
                    res = x0 / SHRINK_DIVISOR; r.choice_kind = KIND_REDUCED;
                end
            end else if (sa > 0) begin
                lim = na * 2 * x2;
                if (snb != 0 && snb != sna) begin
                    res = x1 / SHRINK_DIVISOR; r.choice_kind = KIND_REDUCED;
                end else if ((sna > 0) ? (nb > lim) : (nb < lim)) begin
                    res = x2; r.choice_kind = KIND_CLAMP;
                end else begin
                    un = (nb < 0) ? -nb : nb;
                    ud = 2 * ((na < 0) ? -na : na);
                    res = un / ud;
                    r.choice_kind = KIND_VERTEX;
                end
            end else begin
                mid = na * (x0 + x2);
                if ((sna > 0) ? (nb < mid) : (nb > mid)) begin
                    res = x2; r.choice_kind = KIND_CLAMP;
                end else begin
                    res = x1 / SHRINK_DIVISOR; r.choice_kind = KIND_REDUCED;
                end
            end
        end
        if (res > 128'sd2147483647) res = 128'sd2147483647;
        if (res < -128'sd2147483648) res = -128'sd2147483648;
        r.chosen_step = res[31:0];
        return r;
    endfunction

    function automatic t_in_item make_samples(int xa, int ya, int xb, int yb, int xc, int yc);
        t_in_item it;
        it.step_a = xa;  it.misfit_a = ya;
        it.step_b = xb;  it.misfit_b = yb;
        it.step_c = xc;  it.misfit_c = yc;
        return it;
    endfunction

    // Steps on a small Q16 grid, mostly sorted; misfits from a random parabola.
    function automatic t_in_item shaped_samples();
        int xs[3], ys[3], k, v, off, q;
        for (int i = 0; i < 3; i++) begin
            xs[i] = ($urandom_range(0, 40) - 10) * 32'sh4000 + $urandom_range(0, 3);
        end
        if ($urandom_range(0, 3) != 0) xs.sort();
        k = $urandom_range(0, 12) - 6;
        v = $urandom_range(0, 24) - 8;
        off = $urandom_range(0, 2000) - 1000;
        for (int i = 0; i < 3; i++) begin
            q = (xs[i] >>> 14) - v;
            ys[i] = (k * q * q + off) * 32'sh400;
            if ($urandom_range(0, 4) == 0) ys[i] += $urandom_range(0, 255) - 128;
        end
        if ($urandom_range(0, 9) == 0) xs[$urandom_range(0, 1)] = xs[2];
        return make_samples(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
    endfunction

    function automatic t_in_item noise_samples();
        t_in_item it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (n_accepted == 500 && !pause_done && expected_steps.size() == 0)
                pause_done = 1'b1;
            if (pending_items.size() != 0 && !(n_accepted == 500 && !pause_done)
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                start  <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            wdog = wdog + 1;
            if (start && !busy) begin
                expected_steps.push_back(fit_parabola_step(i_item));
                void'(pending_items.pop_front());
                n_accepted = n_accepted + 1;
                if (n_accepted == n_total / 3) sender_idle_pct = 58;
                if (n_accepted == 2 * n_total / 3) sender_idle_pct = 0;
                wdog = 0;
            end
            if (o_strobe) begin
                wdog = 0;
                if (expected_steps.size() == 0) begin
                    $error("unexpected result: chosen_step=%0d choice_kind=%0d",
                           o_result.chosen_step, o_result.choice_kind);
                    failed = 1'b1;
                end else begin
                    if (o_result.chosen_step !== expected_steps[0].chosen_step) begin
                        $error("chosen_step: expected %0d, actual %0d",
                               expected_steps[0].chosen_step, o_result.chosen_step);
                        failed = 1'b1;
                    end
                    if (o_result.choice_kind !== expected_steps[0].choice_kind) begin
                        $error("choice_kind: expected %0d, actual %0d",
                               expected_steps[0].choice_kind, o_result.choice_kind);
                        failed = 1'b1;
                    end
                    void'(expected_steps.pop_front());
                end
            end
            if (wdog >= WDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int one;
        one = 32'sh10000;
        pending_items.push_back(make_samples(one, 5, one, 7, 2 * one, 9));
        pending_items.push_back(make_samples(0, 0, one, 0, one, 3));
        pending_items.push_back(make_samples(0, 0, one, one, 2 * one, 2 * one));
        pending_items.push_back(make_samples(0, 2 * one, one, one, 2 * one, 0));
        pending_items.push_back(make_samples(-300 * one, 3, one, 3, 2 * one, 3));
        pending_items.push_back(make_samples(0, 4 * one, one, one, 2 * one, 4 * one));
        pending_items.push_back(make_samples(0, one, one, 4 * one, 2 * one, 9 * one));
        pending_items.push_back(make_samples(0, 9 * one, one, 4 * one, 2 * one, one));
        pending_items.push_back(make_samples(0, 0, one, -one, 2 * one, -4 * one));
        pending_items.push_back(make_samples(0, 0, one, one, 2 * one, 0));
        pending_items.push_back(make_samples(0, -4 * one, one, -one, 2 * one, 0));
        pending_items.push_back(make_samples(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                             32'h80000000, 0, 32'h7fffffff));
        pending_items.push_back(make_samples(32'h80000000, 32'h7fffffff, 0,
                                             32'h80000000, 32'h7fffffff, 32'h7fffffff));
        pending_items.push_back(make_samples(32'h80000000, 32'h80000000, 32'h80000001,
                                             32'h7fffffff, 32'h7fffffff, 32'h80000000));
        pending_items.push_back(make_samples(32'h7fffffff, 0, 32'h7fffffff, 0,
                                             32'h7fffffff, 0));
        pending_items.push_back(make_samples(-1, 32'h80000000, 0, 32'h7fffffff,
                                             1, 32'h80000000));
        pending_items.push_back(make_samples(32'hffff0000, -1, 32'h7ffe0000, 32'h40000000,
                                             32'h7fff0000, -1));
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0) pending_items.push_back(noise_samples());
            else pending_items.push_back(shaped_samples());
        end
        n_total = pending_items.size();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (pending_items.size() == 0);
        wait (expected_steps.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!failed && expected_steps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pss_pkg.sv
hdl/pss_div.sv
hdl/parabolic_step_select_core.sv
sim/tb_parabolic_step_select_core.sv
